@@ rtl/vnu_pkg.sv @@
// Shared constants for the vector normalisation unit.
// No dependencies; imported by every vnu module.
package vnu_pkg;
	localparam int COMPONENT_BITS_DEF     = 24;
	localparam int UNIT_FRACTION_BITS_DEF = 22;
	// root is always taken over a 64-bit radicand, giving 32 root bits
	localparam int ROOT_BITS              = 32;
	localparam int RAD_BITS               = 2 * ROOT_BITS;
	localparam int QUEUE_DEPTH            = 4;
	localparam int QUEUE_PTR_BITS         = $clog2(QUEUE_DEPTH);
endpackage

@@ rtl/vector3_normalize_unit.sv @@
// Top level of the vector normalisation unit: front end, item queue, back end.
// Depends on vnu_pkg, vnu_front, vnu_queue and vnu_back.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | in_x, in_y, in_z (signed Q8.16)
//  output  | out_valid/ out_ready | unit_x/y/z (Q2.22), magnitude, zero_vector
//
// One item per cycle sustained while the output is not stalled. The path is 3
// front stages, the queue, 32 root stages, UNIT_FRACTION_BITS+1 divide stages
// and the output register. The root and divide stages each resolve one bit.
// Reset clears all valid flags and the queue. Front and back stall
// independently; the queue absorbs the difference.
module vector3_normalize_unit #(
	parameter int COMPONENT_BITS     = vnu_pkg::COMPONENT_BITS_DEF,
	parameter int UNIT_FRACTION_BITS = vnu_pkg::UNIT_FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COMPONENT_BITS-1:0]     in_x,
	input  logic signed [COMPONENT_BITS-1:0]     in_y,
	input  logic signed [COMPONENT_BITS-1:0]     in_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_x,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_y,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_z,
	output logic [COMPONENT_BITS-1:0]            magnitude,
	output logic                                 zero_vector
);
	import vnu_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int IW = 3*CB + 3 + 2*CB + 1;

	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [3*CB-1:0] push_mag, pop_mag;
	logic [2:0]      push_neg, pop_neg;
	logic [2*CB-1:0] push_sum, pop_sum;
	logic            push_zero, pop_zero;

	vnu_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_mag   (push_mag),
		.push_neg   (push_neg),
		.push_sum   (push_sum),
		.push_zero  (push_zero)
	);

	vnu_queue #(.WIDTH(IW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_mag, push_neg, push_sum, push_zero}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   ({pop_mag, pop_neg, pop_sum, pop_zero})
	);

	vnu_back #(
		.COMPONENT_BITS     (COMPONENT_BITS),
		.UNIT_FRACTION_BITS (UNIT_FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_mag     (pop_mag),
		.pop_neg     (pop_neg),
		.pop_sum     (pop_sum),
		.pop_zero    (pop_zero),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.magnitude   (magnitude),
		.zero_vector (zero_vector)
	);
endmodule

@@ rtl/vnu_front.sv @@
// Front end: takes items, splits sign and magnitude, forms the sum of squares.
// Depends on vnu_pkg.
module vnu_front #(
	parameter int COMPONENT_BITS = vnu_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COMPONENT_BITS-1:0] in_x,
	input  logic signed [COMPONENT_BITS-1:0] in_y,
	input  logic signed [COMPONENT_BITS-1:0] in_z,
	output logic                             push_valid,
	input  logic                             push_ready,
	output logic [3*COMPONENT_BITS-1:0]      push_mag,
	output logic [2:0]                       push_neg,
	output logic [2*COMPONENT_BITS-1:0]      push_sum,
	output logic                             push_zero
);
	import vnu_pkg::*;

	localparam int CB = COMPONENT_BITS;

	logic              en;
	logic              v_s1, v_s2, v_s3;
	logic [CB-1:0]     mag_s1 [3];
	logic [2:0]        neg_s1;
	logic [CB-1:0]     mag_s2 [3];
	logic [2*CB-1:0]   sq_s2 [3];
	logic [2:0]        neg_s2;
	logic [3*CB-1:0]   mag_s3;
	logic [2:0]        neg_s3;
	logic [2*CB-1:0]   sum_s3;
	logic              zero_s3;
	logic [2*CB-1:0]   sum_c;
	logic [CB-1:0]     comp [3];

	assign en       = !v_s3 || push_ready;
	assign in_ready = en;
	assign comp[0]  = in_x;
	assign comp[1]  = in_y;
	assign comp[2]  = in_z;
	assign sum_c    = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][CB-1];
				// most negative value still fits as an unsigned magnitude
				mag_s1[i] <= comp[i][CB-1] ? (CB)'(-comp[i]) : comp[i];
				mag_s2[i] <= mag_s1[i];
				sq_s2[i]  <= (2*CB)'(mag_s1[i]) * (2*CB)'(mag_s1[i]);
			end
			neg_s2  <= neg_s1;
			mag_s3  <= {mag_s2[2], mag_s2[1], mag_s2[0]};
			neg_s3  <= neg_s2;
			sum_s3  <= sum_c;
			zero_s3 <= (sum_c == '0);
		end
	end

	assign push_valid = v_s3;
	assign push_mag   = mag_s3;
	assign push_neg   = neg_s3;
	assign push_sum   = sum_s3;
	assign push_zero  = zero_s3;
endmodule

@@ rtl/vnu_queue.sv @@
// Short item queue between front and back ends.
// Depends on vnu_pkg for its depth.
module vnu_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import vnu_pkg::*;

	logic [WIDTH-1:0]          slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_q, rd_q;
	logic [QUEUE_PTR_BITS:0]   count_q;
	logic                      push, pop;

	assign push_ready = (count_q != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end
endmodule

@@ rtl/vnu_back.sv @@
// Back end: pipelined square root (one root bit a stage), then three
// pipelined restoring dividers (one quotient bit a stage) and the output register.
// Depends on vnu_pkg.
module vnu_back #(
	parameter int COMPONENT_BITS     = vnu_pkg::COMPONENT_BITS_DEF,
	parameter int UNIT_FRACTION_BITS = vnu_pkg::UNIT_FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic [3*COMPONENT_BITS-1:0]          pop_mag,
	input  logic [2:0]                           pop_neg,
	input  logic [2*COMPONENT_BITS-1:0]          pop_sum,
	input  logic                                 pop_zero,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_x,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_y,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_z,
	output logic [COMPONENT_BITS-1:0]            magnitude,
	output logic                                 zero_vector
);
	import vnu_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int UF = UNIT_FRACTION_BITS;
	localparam int UW = UF + 2;
	localparam int QW = UF + 1;
	localparam int G  = ROOT_BITS - CB;
	localparam int NW = UF + ROOT_BITS;
	localparam int DS = UF + 1;

	logic en;

	// square root stages
	logic                  sv_s   [ROOT_BITS];
	logic [RAD_BITS-1:0]   rad_s  [ROOT_BITS];
	logic [ROOT_BITS+1:0]  rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0]  rt_s   [ROOT_BITS];
	logic [3*CB-1:0]       smag_s [ROOT_BITS];
	logic [2:0]            sneg_s [ROOT_BITS];
	logic                  sz_s   [ROOT_BITS];

	// divider stages
	logic                  dv_s   [DS];
	logic [ROOT_BITS-1:0]  droot_s[DS];
	logic [ROOT_BITS-1:0]  drem_s [DS][3];
	logic [QW-1:0]         dq_s   [DS][3];
	logic [3*CB-1:0]       dmag_s [DS];
	logic [2:0]            dneg_s [DS];
	logic                  dz_s   [DS];

	logic                  out_valid_q;
	logic [UW-1:0]         unit_q [3];
	logic [CB-1:0]         magnitude_q;
	logic                  zero_q;

	assign en        = !out_valid_q || out_ready;
	assign pop_ready = en;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		logic                 v_i;
		logic [RAD_BITS-1:0]  rad_i;
		logic [ROOT_BITS+1:0] rem_i;
		logic [ROOT_BITS-1:0] rt_i;
		logic [3*CB-1:0]      mag_i;
		logic [2:0]           neg_i;
		logic                 z_i;
		logic [ROOT_BITS+1:0] trial, tst;

		if (k == 0) begin : g_first
			assign v_i   = pop_valid;
			assign rad_i = RAD_BITS'(pop_sum) << (2*G);
			assign rem_i = '0;
			assign rt_i  = '0;
			assign mag_i = pop_mag;
			assign neg_i = pop_neg;
			assign z_i   = pop_zero;
		end else begin : g_next
			assign v_i   = sv_s[k-1];
			assign rad_i = rad_s[k-1];
			assign rem_i = rem_s[k-1];
			assign rt_i  = rt_s[k-1];
			assign mag_i = smag_s[k-1];
			assign neg_i = sneg_s[k-1];
			assign z_i   = sz_s[k-1];
		end

		assign trial = {rem_i[ROOT_BITS-1:0], rad_i[RAD_BITS-1-2*k -: 2]};
		assign tst   = {rt_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_s[k] <= 1'b0;
			else if (en) sv_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_i;
				smag_s[k] <= mag_i;
				sneg_s[k] <= neg_i;
				sz_s[k]   <= z_i;
				if (trial >= tst) begin
					rem_s[k] <= trial - tst;
					rt_s[k]  <= {rt_i[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial;
					rt_s[k]  <= {rt_i[ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar d = 0; d < DS; d++) begin : g_div
		logic                 v_i;
		logic [ROOT_BITS-1:0] root_i;
		logic [3*CB-1:0]      mag_i;
		logic [2:0]           neg_i;
		logic                 z_i;

		if (d == 0) begin : g_first
			assign v_i    = sv_s[ROOT_BITS-1];
			assign root_i = rt_s[ROOT_BITS-1];
			assign mag_i  = smag_s[ROOT_BITS-1];
			assign neg_i  = sneg_s[ROOT_BITS-1];
			assign z_i    = sz_s[ROOT_BITS-1];
		end else begin : g_next
			assign v_i    = dv_s[d-1];
			assign root_i = droot_s[d-1];
			assign mag_i  = dmag_s[d-1];
			assign neg_i  = dneg_s[d-1];
			assign z_i    = dz_s[d-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[d] <= 1'b0;
			else if (en) dv_s[d] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				droot_s[d] <= root_i;
				dmag_s[d]  <= mag_i;
				dneg_s[d]  <= neg_i;
				dz_s[d]    <= z_i;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [NW-1:0]        num;
			logic [ROOT_BITS-1:0] r_i;
			logic [QW-1:0]        q_i;
			logic [ROOT_BITS:0]   trial;

			// dividend is the magnitude scaled up to the unit fraction plus guard bits
			assign num = NW'(mag_i[l*CB +: CB]) << (UF + G);

			if (d == 0) begin : g_first
				// top part is always below the root, so it starts as the remainder
				assign r_i = ROOT_BITS'(num >> (UF + 1));
				assign q_i = '0;
			end else begin : g_next
				assign r_i = drem_s[d-1][l];
				assign q_i = dq_s[d-1][l];
			end

			assign trial = {r_i, num[UF-d]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (trial >= {1'b0, root_i}) begin
						drem_s[d][l] <= ROOT_BITS'(trial - {1'b0, root_i});
						dq_s[d][l]   <= {q_i[QW-2:0], 1'b1};
					end else begin
						drem_s[d][l] <= trial[ROOT_BITS-1:0];
						dq_s[d][l]   <= {q_i[QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_s[DS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (dz_s[DS-1])         unit_q[l] <= '0;
				else if (dneg_s[DS-1][l]) unit_q[l] <= -UW'(dq_s[DS-1][l]);
				else                    unit_q[l] <= UW'(dq_s[DS-1][l]);
			end
			magnitude_q <= CB'(droot_s[DS-1] >> G);
			zero_q      <= dz_s[DS-1];
		end
	end

	assign out_valid   = out_valid_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign magnitude   = magnitude_q;
	assign zero_vector = zero_q;
endmodule

@@ bench/tb.sv @@
// Self-checking bench for vector3_normalize_unit: directed table then random vectors.
// Depends on vnu_pkg and the vector3_normalize_unit RTL; predictor is local to this file.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vnu_pkg::*;

	localparam int CB   = COMPONENT_BITS_DEF;
	localparam int UFB  = UNIT_FRACTION_BITS_DEF;
	localparam int UW   = UFB + 2;
	localparam int GB   = 32 - CB;
	localparam int N_RANDOM    = 1030;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic signed [UW-1:0] ux;
		logic signed [UW-1:0] uy;
		logic signed [UW-1:0] uz;
		logic [CB-1:0]        mag;
		logic                 zf;
	} norm_t;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		bit                   known;
		norm_t                res;
	} vec_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [CB-1:0] in_x, in_y, in_z;
	logic signed [UW-1:0] unit_x, unit_y, unit_z;
	logic [CB-1:0] magnitude;
	logic zero_vector;

	vector3_normalize_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.magnitude(magnitude), .zero_vector(zero_vector)
	);

	norm_t pending_norms[$];
	int n_errors, n_sent, n_recv, idle_cycles;
	bit stim_done;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic norm_t normalise(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
			logic signed [CB-1:0] z);
		logic [63:0] a[3];
		logic [63:0] sq, rt, q;
		logic signed [CB-1:0] c[3];
		norm_t o;
		c[0] = x; c[1] = y; c[2] = z;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			// most negative value: |c| is exact in 64 bits
			a[i] = c[i][CB-1] ? (64'd1 << CB) - {40'd0, c[i]} : {40'd0, c[i]};
			sq += a[i] * a[i];
		end
		o = '0;
		if (sq == 0) begin
			o.zf = 1'b1;
			return o;
		end
		rt = root64(sq << (2 * GB));
		for (int i = 0; i < 3; i++) begin
			q = (a[i] << (UFB + GB)) / rt;
			if (c[i][CB-1]) q = -q;
			if (i == 0) o.ux = q[UW-1:0];
			else if (i == 1) o.uy = q[UW-1:0];
			else o.uz = q[UW-1:0];
		end
		o.mag = rt[GB +: CB];
		return o;
	endfunction

	task automatic send_vector(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
			logic signed [CB-1:0] z, bit known, norm_t fixed);
		int gap;
		norm_t p;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_x <= x; in_y <= y; in_z <= z;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = normalise(x, y, z);
		if (known && p !== fixed) begin
			n_errors++;
			if (n_errors <= 10)
				$display("table row disagrees with predictor: %h vs %h", fixed, p);
		end
		pending_norms.push_back(known ? fixed : p);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [CB-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
			1: return CB'($signed(CB'($urandom_range(0, 31))) - 16);
			2: return '0;
			default: return CB'($urandom());
		endcase
	endfunction

	// stimulus
	initial begin
		vec_row_t rows[$];
		norm_t k;
		localparam logic signed [CB-1:0] MAXP = {1'b0, {(CB-1){1'b1}}};
		localparam logic signed [CB-1:0] MAXN = {1'b1, {(CB-1){1'b0}}};
		localparam logic signed [CB-1:0] ONE = 1 << 16;
		in_valid = 0; in_x = 0; in_y = 0; in_z = 0;
		n_sent = 0; stim_done = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// zero vector passes through with the flag
		k = '0; k.zf = 1;
		rows.push_back('{0, 0, 0, 1, k});
		// unit axes
		k = '0; k.ux = 1 << UFB; k.mag = ONE;
		rows.push_back('{ONE, 0, 0, 1, k});
		k = '0; k.uy = -(1 << UFB); k.mag = ONE;
		rows.push_back('{0, -ONE, 0, 1, k});
		k = '0; k.uz = 1 << UFB; k.mag = 1;
		rows.push_back('{0, 0, 1, 1, k});
		k = '0; k.ux = -(1 << UFB); k.mag = 1 << (CB-1);
		rows.push_back('{MAXN, 0, 0, 1, k});
		k = '0; k.uz = -(1 << UFB); k.mag = 1;
		rows.push_back('{0, 0, -1, 1, k});
		k = '0;
		rows.push_back('{MAXP, MAXP, MAXP, 0, k});
		rows.push_back('{MAXN, MAXN, MAXN, 0, k});
		rows.push_back('{MAXN, MAXP, MAXN, 0, k});
		rows.push_back('{1, 1, 1, 0, k});
		rows.push_back('{-1, 1, -1, 0, k});
		rows.push_back('{3 * ONE, 4 * ONE, 0, 0, k});
		rows.push_back('{MAXP, 1, -1, 0, k});
		rows.push_back('{24'h555555, 24'haaaaaa, 24'h123456, 0, k});
		foreach (rows[i]) send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
		for (int i = 0; i < N_RANDOM; i++) send_vector(rand_comp(), rand_comp(), rand_comp(), 0, k);
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// result side
	initial begin
		int gap;
		out_ready = 0;
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && arst_n)) @(posedge clk);
		end
	end

	// checker and watchdog
	initial begin
		norm_t want, got;
		n_errors = 0; n_recv = 0; idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (arst_n && out_valid && out_ready) begin
				got = '{unit_x, unit_y, unit_z, magnitude, zero_vector};
				n_recv++;
				if (pending_norms.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) $display("unexpected result item %h", got);
				end else begin
					want = pending_norms.pop_front();
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("item %0d: exp x=%0d y=%0d z=%0d m=%0d zf=%b, ",
								n_recv, want.ux, want.uy, want.uz, want.mag, want.zf,
								"got x=%0d y=%0d z=%0d m=%0d zf=%b",
								got.ux, got.uy, got.uz, got.mag, got.zf);
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Stalled after %0d vectors sent and %0d results checked.",
					n_sent, n_recv);
				$display("RESULT: ERROR");
				$finish;
			end
			if (stim_done && pending_norms.size() == 0) begin
				repeat (100) begin
					@(posedge clk);
					if (out_valid && out_ready) begin
						n_errors++;
						$display("surplus result item after drain");
					end
				end
				$display("Sent %0d vectors (directed and random), checked %0d normalised results.",
					n_sent, n_recv);
				$display("Mismatches: %0d", n_errors);
				if (n_errors == 0) $display("RESULT: OK");
				else $display("RESULT: ERROR");
				$finish;
			end
		end
	end
endmodule
